FILE: hw/rtl/wmd_pkg.sv
`timescale 1ns / 1ps

package wmd_pkg;

	localparam int unsigned GROUP_BITS = 16;
	localparam int unsigned COLUMN_BITS = 14;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SAMPLES_PER_COLUMN = 2'd0,
		REG_COLUMN_LIMIT       = 2'd1,
		REG_HIGH_QUALITY       = 2'd2,
		REG_STEREO             = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GROUP_BITS-1:0]  samples_per_column;
		logic [COLUMN_BITS-1:0] column_limit;
		logic                   high_quality;
		logic                   stereo;
	} cfg_t;

endpackage

FILE: hw/rtl/wmd_cfg_regs.sv
`timescale 1ns / 1ps

module wmd_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [wmd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [wmd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output wmd_pkg::cfg_t                        cfg
);
	import wmd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_column <= GROUP_BITS'(1);
			cfg_q.column_limit       <= COLUMN_BITS'(1024);
			cfg_q.high_quality       <= 1'b1;
			cfg_q.stereo             <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLES_PER_COLUMN: cfg_q.samples_per_column <= cfg_data[GROUP_BITS-1:0];
				REG_COLUMN_LIMIT:       cfg_q.column_limit <= cfg_data[COLUMN_BITS-1:0];
				REG_HIGH_QUALITY:       cfg_q.high_quality <= cfg_data[0];
				REG_STEREO:             cfg_q.stereo <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/wmd_column_core.sv
`timescale 1ns / 1ps

// Group position, column count and running peaks. The state advances on a
// step; the column for that step is presented combinationally with col_emit.
module wmd_column_core #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wmd_pkg::cfg_t                 cfg,
	input  logic                          step,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic                          frame_start_in,
	output logic                          col_emit,
	output logic signed [SAMPLE_BITS-1:0] col_min_left,
	output logic signed [SAMPLE_BITS-1:0] col_max_left,
	output logic signed [SAMPLE_BITS-1:0] col_min_right,
	output logic signed [SAMPLE_BITS-1:0] col_max_right,
	output logic                          col_last
);
	import wmd_pkg::*;

	logic [GROUP_BITS-1:0]         pos_q, pos, pos_d, skip;
	logic [COLUMN_BITS-1:0]        cols_q, cols, cols_d;
	logic signed [SAMPLE_BITS-1:0] mnl_q, mxl_q, mnr_q, mxr_q;
	logic signed [SAMPLE_BITS-1:0] mnl, mxl, mnr, mxr;
	logic signed [SAMPLE_BITS-1:0] mnl_d, mxl_d, mnr_d, mxr_d;
	logic signed [SAMPLE_BITS-1:0] mnl_n, mxl_n, mnr_n, mxr_n;
	logic                          limit_hit, end_of_group, pick_first;
	logic [COLUMN_BITS:0]          cols_inc;

	always_comb begin
		// A new file clears position, count and peaks before the frame is used.
		pos  = frame_start_in ? '0 : pos_q;
		cols = frame_start_in ? '0 : cols_q;
		mnl  = frame_start_in ? '0 : mnl_q;
		mxl  = frame_start_in ? '0 : mxl_q;
		mnr  = frame_start_in ? '0 : mnr_q;
		mxr  = frame_start_in ? '0 : mxr_q;

		skip = (cfg.samples_per_column == '0) ? GROUP_BITS'(1) : cfg.samples_per_column;
		limit_hit    = cols >= cfg.column_limit;
		end_of_group = pos >= (skip - GROUP_BITS'(1));
		pick_first   = !cfg.high_quality || (skip == GROUP_BITS'(1));
		cols_inc     = {1'b0, cols} + (COLUMN_BITS+1)'(1);

		mxl_n = (left_in > mxl) ? left_in : mxl;
		mnl_n = (left_in < mnl) ? left_in : mnl;
		mxr_n = (cfg.stereo && (right_in > mxr)) ? right_in : mxr;
		mnr_n = (cfg.stereo && (right_in < mnr)) ? right_in : mnr;

		col_emit      = 1'b0;
		col_min_left  = '0;
		col_max_left  = '0;
		col_min_right = '0;
		col_max_right = '0;
		col_last      = (cols_inc == {1'b0, cfg.column_limit});

		pos_d  = pos;
		cols_d = cols;
		mnl_d  = mnl;
		mxl_d  = mxl;
		mnr_d  = mnr;
		mxr_d  = mxr;

		if (!limit_hit) begin
			pos_d = end_of_group ? '0 : pos + GROUP_BITS'(1);
			if (pick_first) begin
				// Low-quality mode, and a group of one frame, leave the running peaks untouched.
				if (pos == '0) begin
					col_emit      = 1'b1;
					col_min_left  = left_in;
					col_max_left  = left_in;
					col_min_right = cfg.stereo ? right_in : '0;
					col_max_right = cfg.stereo ? right_in : '0;
				end
			end else if (end_of_group) begin
				col_emit      = 1'b1;
				col_min_left  = mnl_n;
				col_max_left  = mxl_n;
				col_min_right = cfg.stereo ? mnr_n : '0;
				col_max_right = cfg.stereo ? mxr_n : '0;
				mnl_d = '0;
				mxl_d = '0;
				mnr_d = '0;
				mxr_d = '0;
			end else begin
				mnl_d = mnl_n;
				mxl_d = mxl_n;
				mnr_d = mnr_n;
				mxr_d = mxr_n;
			end
			if (col_emit) begin
				cols_d = cols_inc[COLUMN_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cols_q <= '0;
			mnl_q  <= '0;
			mxl_q  <= '0;
			mnr_q  <= '0;
			mxr_q  <= '0;
		end else if (step) begin
			pos_q  <= pos_d;
			cols_q <= cols_d;
			mnl_q  <= mnl_d;
			mxl_q  <= mxl_d;
			mnr_q  <= mnr_d;
			mxr_q  <= mxr_d;
		end
	end

endmodule

FILE: hw/rtl/waveform_minmax_decimator.sv
`timescale 1ns / 1ps
// An accepted frame moves from the input register to the result register, where its column
// is offered once the result register is free; frames that close no column produce nothing.
// Throughput: one frame per cycle unless stalled, set by the single compare-and-update pass.
// Reset (arst_n low, asynchronous): counters and peaks clear, no transaction is held, and the
// registers return to 1 frame per column, 1024 columns, high quality, mono.

// Min/max waveform decimator. Each input transaction is one sample frame. Frames are grouped
// samples_per_column at a time; every group yields at most one display column.
//
// Structure:
//   - Input register (stage 1) holds one accepted frame.
//   - The column core compares the frame against the running peaks, updates the group
//     position and the column count, and decides whether a column leaves with this frame.
//   - Result register (stage 2) holds the column until the consumer takes it.
// Stage 1 moves on whenever stage 2 is empty or being drained, so a held result never blocks
// acceptance of the next frame as long as the consumer keeps up.
//
// In high-quality mode peaks start at zero, so a min/max column spans zero. In low-quality
// mode, or with one frame per column, the first frame of a group forms the column. Once
// column_limit columns have left, frames are absorbed until a frame marked frame_start.
module waveform_minmax_decimator #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// Configuration write port.
	input  logic                                 cfg_write,
	input  logic [wmd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [wmd_pkg::CFG_DATA_BITS-1:0]    cfg_data,

	// Frame input.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        left_sample,
	input  logic signed [SAMPLE_BITS-1:0]        right_sample,
	input  logic                                 frame_start,

	// Column output.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        min_left,
	output logic signed [SAMPLE_BITS-1:0]        max_left,
	output logic signed [SAMPLE_BITS-1:0]        min_right,
	output logic signed [SAMPLE_BITS-1:0]        max_right,
	output logic                                 last_column
);
	import wmd_pkg::*;

	cfg_t cfg;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] left_s1, right_s1;
	logic                          frame_start_s1;

	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] min_left_s2, max_left_s2, min_right_s2, max_right_s2;
	logic                          last_s2;

	logic                          advance, step;
	logic                          col_emit, col_last;
	logic signed [SAMPLE_BITS-1:0] col_min_left, col_max_left, col_min_right, col_max_right;

	wmd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// The frame in stage 1 is processed when the result register can take a new column.
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			left_s1        <= left_sample;
			right_s1       <= right_sample;
			frame_start_s1 <= frame_start;
		end
	end

	wmd_column_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.step          (step),
		.left_in       (left_s1),
		.right_in      (right_s1),
		.frame_start_in(frame_start_s1),
		.col_emit      (col_emit),
		.col_min_left  (col_min_left),
		.col_max_left  (col_max_left),
		.col_min_right (col_min_right),
		.col_max_right (col_max_right),
		.col_last      (col_last)
	);

	// The result register loads a column or empties once its content is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && col_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && col_emit) begin
			min_left_s2  <= col_min_left;
			max_left_s2  <= col_max_left;
			min_right_s2 <= col_min_right;
			max_right_s2 <= col_max_right;
			last_s2      <= col_last;
		end
	end

	assign out_valid   = valid_s2;
	assign min_left    = min_left_s2;
	assign max_left    = max_left_s2;
	assign min_right   = min_right_s2;
	assign max_right   = max_right_s2;
	assign last_column = last_s2;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Testbench for the min/max waveform decimator.
//
// Frames go in on a valid/ready channel and display columns come out on another. A
// predictor inside this file keeps its own copy of the group position, the column count,
// the running peaks and the four settings. Every accepted frame is run through it, and any
// column it produces is queued unless a directed row says otherwise. Every column the block
// hands out is compared field by field with the oldest queued column.
//
// The run starts with a short directed table and then moves on to random phases. Each phase
// drains all pending columns and rewrites the settings. Settings change only between phases,
// so a phase that starts without frame_start picks up a group that is already half done.
module tb;
	import wmd_pkg::*;

	// The block takes a frame every cycle unless the column side is stalled. Stalls and settings
	// changes stay far below IDLE_LIMIT, so reaching that limit with no transaction on either
	// side means the block has hung.
	localparam int IDLE_LIMIT = 2000;
	localparam int FRAME_TARGET = 2000;

	typedef logic signed [15:0] sample_t;

	typedef struct packed {
		sample_t lo_left;
		sample_t hi_left;
		sample_t lo_right;
		sample_t hi_right;
		logic    last;
	} column_t;

	typedef enum {ROW_CFG, ROW_FRAME} row_kind_t;

	// Directed rows either defer to the predictor, assert that no column comes out, or carry
	// a column typed in by hand.
	typedef enum {CHK_PREDICT, CHK_QUIET, CHK_TYPED} row_check_t;

	typedef struct {
		row_kind_t  kind;
		row_check_t check;
		cfg_reg_t   reg_id;
		logic [15:0] value;
		sample_t    left;
		sample_t    right;
		bit         start;
		column_t    column;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	sample_t     left_sample = '0;
	sample_t     right_sample = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	sample_t     min_left;
	sample_t     max_left;
	sample_t     min_right;
	sample_t     max_right;
	logic        last_column;

	// Predictor copy of the settings, at their reset values.
	logic [15:0] grp_size = 16'd1;
	logic [13:0] col_cap = 14'd1024;
	bit          hq_mode = 1'b1;
	bit          two_ch = 1'b0;

	// Predictor copy of the block state.
	logic [15:0] grp_pos = '0;
	logic [13:0] cols_out = '0;
	sample_t     peak_lo_l = '0;
	sample_t     peak_hi_l = '0;
	sample_t     peak_lo_r = '0;
	sample_t     peak_hi_r = '0;

	column_t     column_q[$];
	stim_row_t   stim_table[$];
	int          mismatches = 0;
	int          frames_used = 0;
	int          idle_cycles = 0;
	int          rx_hold = 0;
	bit          rx_calm = 1'b0;
	bit          tx_calm = 1'b0;

	waveform_minmax_decimator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_left     (min_left),
		.max_left     (max_left),
		.min_right    (min_right),
		.max_right    (max_right),
		.last_column  (last_column)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Pause lengths for both sides: mostly none or short, now and then a long one.
	function automatic int pause_length(bit calm);
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic sample_t rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			1, 2: return sample_t'($signed($urandom_range(0, 128)) - 64);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic void apply_cfg(cfg_reg_t id, logic [15:0] value);
		case (id)
			REG_SAMPLES_PER_COLUMN: grp_size = value;
			REG_COLUMN_LIMIT:       col_cap = value[13:0];
			REG_HIGH_QUALITY:       hq_mode = value[0];
			REG_STEREO:             two_ch = value[0];
			default: ;
		endcase
	endfunction

	// Runs one frame through the predictor. Returns 1 when the frame closes a column and
	// fills col. Once the column limit has been reached a frame without start has no effect at all.
	function automatic bit decimate_frame(input sample_t l, input sample_t r, input bit start,
			output column_t col);
		int span;
		bit closing;
		bit emit;
		col = '0;
		emit = 1'b0;
		// frame_start wipes the file state before the frame itself is used.
		if (start) begin
			grp_pos = '0;
			cols_out = '0;
			{peak_lo_l, peak_hi_l, peak_lo_r, peak_hi_r} = '0;
		end
		// A group size of zero behaves as one.
		span = (grp_size == 16'd0) ? 1 : int'(grp_size);
		if (cols_out >= col_cap)
			return 1'b0;
		// A position at or past the group end closes the group. That also covers a group
		// size lowered while a group was in progress.
		closing = int'(grp_pos) >= span - 1;
		if (!hq_mode || span == 1) begin
			// First-sample mode leaves the running peaks alone.
			if (grp_pos == 16'd0) begin
				emit = 1'b1;
				col.lo_left = l;
				col.hi_left = l;
				if (two_ch) begin
					col.lo_right = r;
					col.hi_right = r;
				end
			end
		end else begin
			if (l > peak_hi_l) peak_hi_l = l;
			if (l < peak_lo_l) peak_lo_l = l;
			if (two_ch) begin
				if (r > peak_hi_r) peak_hi_r = r;
				if (r < peak_lo_r) peak_lo_r = r;
			end
			if (closing) begin
				emit = 1'b1;
				col.lo_left = peak_lo_l;
				col.hi_left = peak_hi_l;
				if (two_ch) begin
					col.lo_right = peak_lo_r;
					col.hi_right = peak_hi_r;
				end
				{peak_lo_l, peak_hi_l, peak_lo_r, peak_hi_r} = '0;
			end
		end
		grp_pos = closing ? 16'd0 : grp_pos + 16'd1;
		if (emit) begin
			col.last = (int'(cols_out) + 1 == int'(col_cap));
			cols_out = cols_out + 14'd1;
		end
		return emit;
	endfunction

	function automatic column_t mk_col(int lo_l, int hi_l, int lo_r, int hi_r, bit last);
		column_t col;
		col.lo_left = sample_t'(lo_l);
		col.hi_left = sample_t'(hi_l);
		col.lo_right = sample_t'(lo_r);
		col.hi_right = sample_t'(hi_r);
		col.last = last;
		return col;
	endfunction

	function automatic void add_cfg(cfg_reg_t id, logic [15:0] value);
		stim_row_t row;
		row = '{kind: ROW_CFG, check: CHK_PREDICT, reg_id: id, value: value,
			left: '0, right: '0, start: 1'b0, column: '0};
		stim_table.insert(stim_table.size(), row);
	endfunction

	function automatic void add_frame(int l, int r, bit start, row_check_t check,
			column_t col);
		stim_row_t row;
		row = '{kind: ROW_FRAME, check: check, reg_id: REG_SAMPLES_PER_COLUMN, value: '0,
			left: sample_t'(l), right: sample_t'(r), start: start, column: col};
		stim_table.insert(stim_table.size(), row);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// The column side stalls in random bursts unless the current phase asks for a calm run.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				rx_hold = pause_length(rx_calm);
		end
	end

	// Columns are sampled at the rising edge, where both sides see the same handshake.
	always @(posedge clk) begin : column_check
		column_t want;
		if (arst_n && out_valid && out_ready) begin
			if (column_q.size() == 0) begin
				$display("%0t: column with none expected, got %0d %0d %0d %0d last %0d",
					$time, min_left, max_left, min_right, max_right, last_column);
				mismatches++;
			end else begin
				want = column_q.pop_front();
				check_field("min_left", want.lo_left, min_left);
				check_field("max_left", want.hi_left, max_left);
				check_field("min_right", want.lo_right, min_right);
				check_field("max_right", want.hi_right, max_right);
				check_field("last_column", want.last, last_column);
			end
		end
	end

	// Watchdog: any transaction on either side counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t id, input logic [15:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= id;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		apply_cfg(id, value);
	endtask

	// Stops sending and waits until every queued column has come out. A frame that closes
	// no column may still sit in the pipeline at that point, so the task waits on until it has
	// passed both stages before any register may change.
	task automatic drain_columns();
		@(negedge clk);
		in_valid <= 1'b0;
		while (column_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Presents one frame after an idle gap given by gap and holds it until the block takes it. The
	// frame is then run through the predictor, and the resulting column is queued according
	// to check.
	task automatic send_frame(input sample_t l, input sample_t r, input bit start,
			input row_check_t check, input column_t typed, input int gap);
		column_t col;
		bit emit;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		frame_start <= start;
		do
			@(posedge clk);
		while (!in_ready);
		emit = decimate_frame(l, r, start, col);
		frames_used++;
		if (check == CHK_TYPED)
			column_q.insert(column_q.size(), typed);
		else if (check == CHK_PREDICT && emit)
			column_q.insert(column_q.size(), col);
	endtask

	initial begin
		stim_row_t row;
		int phase_frames;
		int pick;
		logic [15:0] group_size;
		logic [15:0] cap;

		// Directed table. The block starts at one frame per column, 1024 columns, high
		// quality and mono. With one frame per column, every frame becomes a column of its
		// own. In mono the right outputs stay at zero whatever the right input carries.
		add_frame(32767, -32768, 1'b1, CHK_TYPED, mk_col(32767, 32767, 0, 0, 1'b0));
		add_frame(-32768, 32767, 1'b0, CHK_TYPED, mk_col(-32768, -32768, 0, 0, 1'b0));
		add_cfg(REG_STEREO, 16'd1);
		add_frame(-1, -32768, 1'b0, CHK_TYPED, mk_col(-1, -1, -32768, -32768, 1'b0));
		// A group size of zero behaves as one.
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'd0);
		add_frame(1234, -4321, 1'b0, CHK_TYPED, mk_col(1234, 1234, -4321, -4321, 1'b0));
		// Groups of four with min/max tracking. The peaks start at zero, so a column of
		// all-positive left samples still reports a minimum of zero.
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'd4);
		add_frame(100, -5, 1'b1, CHK_QUIET, '0);
		add_frame(-200, 7, 1'b0, CHK_QUIET, '0);
		add_frame(5, 32767, 1'b0, CHK_QUIET, '0);
		add_frame(1, 1, 1'b0, CHK_TYPED, mk_col(-200, 100, -5, 32767, 1'b0));
		add_frame(10, -1, 1'b0, CHK_QUIET, '0);
		add_frame(20, -2, 1'b0, CHK_QUIET, '0);
		add_frame(30, -3, 1'b0, CHK_QUIET, '0);
		add_frame(40, -4, 1'b0, CHK_TYPED, mk_col(0, 40, -4, 0, 1'b0));
		// A group of five is started and the size is then lowered below the current position,
		// so the next frame closes the group.
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'd5);
		add_frame(-7, 9, 1'b1, CHK_PREDICT, '0);
		add_frame(3, -3, 1'b0, CHK_PREDICT, '0);
		add_frame(8, -8, 1'b0, CHK_PREDICT, '0);
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'd2);
		add_frame(-1, 2, 1'b0, CHK_PREDICT, '0);
		// The mode flips back and forth in the middle of a group. Position and peaks carry
		// over as they are.
		add_cfg(REG_HIGH_QUALITY, 16'd0);
		add_frame(555, -555, 1'b0, CHK_PREDICT, '0);
		add_frame(6, 6, 1'b0, CHK_PREDICT, '0);
		add_cfg(REG_HIGH_QUALITY, 16'd1);
		add_frame(-9, 4, 1'b0, CHK_PREDICT, '0);
		add_cfg(REG_HIGH_QUALITY, 16'd0);
		add_frame(11, 12, 1'b0, CHK_PREDICT, '0);
		// With a column limit of zero, nothing ever comes out.
		add_cfg(REG_COLUMN_LIMIT, 16'd0);
		add_frame(32767, 32767, 1'b1, CHK_QUIET, '0);
		// With a limit of two, the second column is flagged last and the frames after it are
		// absorbed.
		add_cfg(REG_COLUMN_LIMIT, 16'd2);
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'd1);
		add_frame(-32768, -32768, 1'b1, CHK_TYPED,
			mk_col(-32768, -32768, -32768, -32768, 1'b0));
		add_frame(32767, -1, 1'b0, CHK_TYPED, mk_col(32767, 32767, -1, -1, 1'b1));
		add_frame(0, 0, 1'b0, CHK_QUIET, '0);
		// Largest group and a column limit of 8192.
		add_cfg(REG_COLUMN_LIMIT, 16'd8192);
		add_cfg(REG_SAMPLES_PER_COLUMN, 16'hFFFF);
		add_cfg(REG_HIGH_QUALITY, 16'd1);
		add_cfg(REG_STEREO, 16'd0);
		add_frame(-32768, 32767, 1'b1, CHK_QUIET, '0);
		add_frame(32767, -32768, 1'b0, CHK_QUIET, '0);
		add_cfg(REG_HIGH_QUALITY, 16'd0);
		add_frame(1, 2, 1'b1, CHK_PREDICT, '0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.kind == ROW_CFG) begin
				drain_columns();
				write_reg(row.reg_id, row.value);
			end else begin
				send_frame(row.left, row.right, row.start, row.check, row.column,
					pause_length(1'b0));
			end
		end

		// Random phases. Each one drains the pipeline, rewrites all four registers and sends
		// a burst of frames. Most group sizes are small so that columns come often. frame_start
		// opens most phases and turns up now and then in between, which reopens the
		// column limit.
		while (frames_used < FRAME_TARGET) begin
			drain_columns();
			pick = $urandom_range(0, 99);
			if (pick < 10)
				group_size = 16'd0;
			else if (pick < 55)
				group_size = 16'($urandom_range(1, 4));
			else if (pick < 85)
				group_size = 16'($urandom_range(5, 16));
			else if (pick < 96)
				group_size = 16'($urandom_range(17, 200));
			else if (pick < 98)
				group_size = 16'hFFFF;
			else
				group_size = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 5)
				cap = 16'd0;
			else if (pick < 30)
				cap = 16'($urandom_range(1, 8));
			else if (pick < 40)
				cap = 16'd8192;
			else if (pick < 45)
				cap = 16'($urandom_range(0, 16383));
			else
				cap = 16'($urandom_range(9, 1024));
			write_reg(REG_SAMPLES_PER_COLUMN, group_size);
			write_reg(REG_COLUMN_LIMIT, cap);
			write_reg(REG_HIGH_QUALITY, 16'($urandom_range(0, 1)));
			write_reg(REG_STEREO, 16'($urandom_range(0, 1)));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			phase_frames = $urandom_range(20, 120);
			for (int n = 0; n < phase_frames; n++) begin
				send_frame(rand_sample(), rand_sample(),
					(n == 0 && $urandom_range(0, 4) != 0) || $urandom_range(0, 39) == 0,
					CHK_PREDICT, '0, pause_length(tx_calm));
			end
		end

		drain_columns();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
